// File: sv/sellmeier_refractive_index_defines.svh
// Assertion macros for the Sellmeier refractive index block.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef SELLMEIER_REFRACTIVE_INDEX_DEFINES_SVH
`define SELLMEIER_REFRACTIVE_INDEX_DEFINES_SVH

// Same-cycle implication.
`define SRI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sri assertion failed");

// Next-cycle implication.
`define SRI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sri assertion failed");

`endif

// File: sv/sri_pkg.sv
// Package for the Sellmeier refractive index block: widths, constants,
// status codes, register indexes and the configuration struct. No dependencies.
package sri_pkg;

    localparam int WAVE_W         = 22;
    localparam int TERM_MAX       = 5;
    localparam int TERM_COUNT_DEF = 5;
    localparam int TERM_W         = 64;
    localparam int ADDR_W         = 6;
    localparam int DATA_W         = 64;

    localparam int W2_W      = 44;
    localparam int L2_X_W    = 46;
    localparam int L2_PROD_W = 96;
    localparam int L2_SHIFT  = 61;
    localparam int L2_QW     = 33;
    localparam logic [L2_X_W-1:0] L2_BIAS  = 46'd7812;
    localparam logic [47:0]       L2_RECIP = 48'd147573952589677;

    localparam int D_W     = 38;
    localparam int DMAG_W  = 36;
    localparam int TNUM_W  = 65;
    localparam int TQ_W    = 41;
    localparam int TDIV_W  = DMAG_W + TQ_W;
    localparam logic [TQ_W-1:0] TERM_CLAMP = 41'h100_0000_0000;

    localparam int RAD_W   = 44;
    localparam logic signed [RAD_W-1:0] ONE_Q28 = 44'sh000_1000_0000;
    localparam int SQ_W      = 64;
    localparam int SQ_STAGES = 32;
    localparam int N_W       = 32;

    localparam logic [2:0] REG_MIN   = 3'd0;
    localparam logic [2:0] REG_MAX   = 3'd1;
    localparam logic [2:0] REG_TERM1 = 3'd2;
    localparam logic [2:0] REG_TERM2 = 3'd3;
    localparam logic [2:0] REG_TERM3 = 3'd4;
    localparam logic [2:0] REG_TERM4 = 3'd5;
    localparam logic [2:0] REG_TERM5 = 3'd6;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAND = 2'd1,
        ST_POLE = 2'd2,
        ST_NEG  = 2'd3
    } status_t;

    typedef struct packed {
        logic [WAVE_W-1:0]                min_wave;
        logic [WAVE_W-1:0]                max_wave;
        logic [TERM_MAX-1:0][TERM_W-1:0]  term;
    } cfg_t;

endpackage

// File: sv/sellmeier_refractive_index.sv
// Sellmeier refractive index, fully pipelined: one word per cycle sustained while the
// pipeline is not held on m_ready. The per-term dividers (41 stages) and the square
// root (32 stages) set the depth; l2 takes two stages.
// The whole pipeline holds while a result waits on m_ready.
// aresetn (synchronous, active low) clears all valid bits and config regs; max_wave to all ones.
// Depends on sri_pkg, sri_regs, sri_udiv, sri_isqrt and the defines header.
`include "sellmeier_refractive_index_defines.svh"

module sellmeier_refractive_index #(
    parameter int TERM_COUNT = sri_pkg::TERM_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sri_pkg::ADDR_W-1:0]  paddr,
    input  logic [sri_pkg::DATA_W-1:0]  pwdata,
    output logic [sri_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sri_pkg::WAVE_W-1:0]  s_wavelength,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sri_pkg::N_W-1:0]     m_refractive_index,
    output logic [1:0]                  m_status
);

    localparam int PRE_DEPTH = 2 + 2 + 2 + sri_pkg::TQ_W + 3 + sri_pkg::SQ_STAGES;
    localparam int RW = sri_pkg::RAD_W;

    sri_pkg::cfg_t cfg;
    logic en;
    logic [PRE_DEPTH-1:0] valid_reg;
    logic m_valid_reg;

    sri_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg   <= {valid_reg[PRE_DEPTH-2:0], s_valid};
            m_valid_reg <= valid_reg[PRE_DEPTH-1];
        end
    end

    // band check and square
    logic [sri_pkg::WAVE_W-1:0] w1_reg;
    logic                       oob1_reg, oob2_reg;
    logic [sri_pkg::W2_W-1:0]   w2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            w1_reg   <= s_wavelength;
            oob1_reg <= (s_wavelength < cfg.min_wave) || (s_wavelength > cfg.max_wave);
            w2_reg   <= sri_pkg::W2_W'(w1_reg) * sri_pkg::W2_W'(w1_reg);
            oob2_reg <= oob1_reg;
        end
    end

    // l2 in Q.24 square micrometres: floor((4*w*w + 7812) / 15625) by reciprocal
    logic [sri_pkg::L2_X_W-1:0]    l2_x;
    logic [23:0]                   x_lo, m_lo, m_hi;
    logic [21:0]                   x_hi;
    logic [47:0]                   p_ll_reg, p_lh_reg;
    logic [45:0]                   p_hl_reg, p_hh_reg;
    logic [sri_pkg::L2_PROD_W-1:0] l2_prod;
    logic [sri_pkg::L2_QW-1:0]     l2_reg;
    logic                          oob3_reg, oob4_reg, oob5_reg, oob6_reg;

    assign l2_x = {w2_reg, 2'b00} + sri_pkg::L2_BIAS;
    assign x_lo = l2_x[23:0];
    assign x_hi = l2_x[45:24];
    assign m_lo = sri_pkg::L2_RECIP[23:0];
    assign m_hi = sri_pkg::L2_RECIP[47:24];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ll_reg <= 48'(x_lo) * 48'(m_lo);
            p_lh_reg <= 48'(x_lo) * 48'(m_hi);
            p_hl_reg <= 46'(x_hi) * 46'(m_lo);
            p_hh_reg <= 46'(x_hi) * 46'(m_hi);
            oob3_reg <= oob2_reg;
        end
    end

    assign l2_prod = sri_pkg::L2_PROD_W'(p_ll_reg)
                   + (sri_pkg::L2_PROD_W'(p_lh_reg) << 24)
                   + (sri_pkg::L2_PROD_W'(p_hl_reg) << 24)
                   + (sri_pkg::L2_PROD_W'(p_hh_reg) << 48);

    always_ff @(posedge aclk) begin
        if (en) begin
            l2_reg   <= l2_prod[sri_pkg::L2_SHIFT +: sri_pkg::L2_QW];
            oob4_reg <= oob3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oob5_reg <= oob4_reg;
            oob6_reg <= oob5_reg;
        end
    end

    // per-term lanes
    logic signed [RW-1:0]  sterm_reg [TERM_COUNT];
    logic [TERM_COUNT-1:0] tpole_reg;
    logic [TERM_COUNT-1:0] toob_reg;

    for (genvar g = 0; g < TERM_COUNT; g++) begin : g_lane
        logic [31:0]                  kraw, lraw, kmag;
        logic                         kneg, dneg;
        logic signed [sri_pkg::D_W-1:0] lq, d;
        logic [sri_pkg::DMAG_W-1:0]   dmag;
        logic [sri_pkg::TNUM_W-1:0]   num_reg, nq, nq_reg;
        logic [sri_pkg::DMAG_W-1:0]   dmag_reg, dmag2_reg;
        logic                         neg_reg, pole_reg, neg2_reg, pole2_reg, ovf_reg;
        logic [sri_pkg::TNUM_W-1:0]   dv_num;
        logic [sri_pkg::DMAG_W-1:0]   dv_den;
        logic [sri_pkg::TQ_W-1:0]     q, qc;
        logic [3:0]                   tg;

        assign kraw = cfg.term[g][63:32];
        assign lraw = cfg.term[g][31:0];
        assign kneg = kraw[31];
        assign kmag = kneg ? (~kraw + 32'd1) : kraw;
        assign lq   = {{2{lraw[31]}}, lraw, 4'b0};
        assign d    = $signed({5'b0, l2_reg}) - lq;
        assign dneg = d[sri_pkg::D_W-1];
        assign dmag = sri_pkg::DMAG_W'(dneg ? -d : d);

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg  <= sri_pkg::TNUM_W'(kmag) * sri_pkg::TNUM_W'(l2_reg);
                dmag_reg <= dmag;
                neg_reg  <= kneg ^ dneg;
                pole_reg <= (d == '0);
            end
        end

        assign nq = num_reg + sri_pkg::TNUM_W'(dmag_reg >> 1);

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg    <= nq;
                dmag2_reg <= dmag_reg;
                neg2_reg  <= neg_reg;
                pole2_reg <= pole_reg;
                ovf_reg   <= sri_pkg::TDIV_W'(nq)
                             >= (sri_pkg::TDIV_W'(dmag_reg) << sri_pkg::TQ_W);
            end
        end

        assign dv_num = (ovf_reg || pole2_reg) ? '0 : nq_reg;
        assign dv_den = pole2_reg ? sri_pkg::DMAG_W'(1) : dmag2_reg;

        sri_udiv #(
            .NW(sri_pkg::TNUM_W), .DW(sri_pkg::DMAG_W), .QW(sri_pkg::TQ_W), .TW(4)
        ) u_tdiv (
            .aclk, .en, .num(dv_num), .den(dv_den),
            .tag_in({oob6_reg, neg2_reg, ovf_reg, pole2_reg}),
            .quo(q), .tag_out(tg)
        );

        assign qc = (tg[1] || q > sri_pkg::TERM_CLAMP) ? sri_pkg::TERM_CLAMP : q;

        always_ff @(posedge aclk) begin
            if (en) begin
                sterm_reg[g] <= tg[2] ? RW'(0) - RW'(qc) : RW'(qc);
                tpole_reg[g] <= tg[0];
                toob_reg[g]  <= tg[3];
            end
        end
    end

    // sum, then status and radicand
    logic signed [RW-1:0] rad_sum, rad_reg;
    logic                 pole_s_reg, oob_s_reg;

    always_comb begin
        rad_sum = sri_pkg::ONE_Q28;
        for (int g = 0; g < TERM_COUNT; g++) begin
            rad_sum = rad_sum + sterm_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg    <= rad_sum;
            pole_s_reg <= |tpole_reg;
            oob_s_reg  <= |toob_reg;
        end
    end

    sri_pkg::status_t st_next, st_reg, st_out;
    logic [sri_pkg::SQ_W-1:0] sq_in_reg;
    logic sat_reg, sat_out;
    logic [sri_pkg::N_W-1:0] root;
    logic [2:0] sq_tag;

    always_comb begin
        priority if (oob_s_reg)      st_next = sri_pkg::ST_BAND;
        else if (pole_s_reg)         st_next = sri_pkg::ST_POLE;
        else if (rad_reg[RW-1])      st_next = sri_pkg::ST_NEG;
        else                         st_next = sri_pkg::ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg    <= st_next;
            sat_reg   <= !rad_reg[RW-1] && (rad_reg[RW-2:36] != '0);
            sq_in_reg <= {rad_reg[35:0], 28'b0};
        end
    end

    sri_isqrt #(.TW(3)) u_sqrt (
        .aclk, .en, .rad_in(sq_in_reg), .tag_in({st_reg, sat_reg}),
        .root, .tag_out(sq_tag)
    );

    assign st_out  = sri_pkg::status_t'(sq_tag[2:1]);
    assign sat_out = sq_tag[0];

    logic [sri_pkg::N_W-1:0] m_index_reg;
    sri_pkg::status_t        m_status_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_status_reg <= st_out;
            if (st_out != sri_pkg::ST_OK) begin
                m_index_reg <= '0;
            end else if (sat_out) begin
                m_index_reg <= '1;
            end else begin
                m_index_reg <= root;
            end
        end
    end

    assign m_refractive_index = m_index_reg;
    assign m_status           = m_status_reg;

    `SRI_ASSERT_NOW(a_fail_zero, m_valid && m_status != sri_pkg::ST_OK, m_refractive_index == '0)
    `SRI_ASSERT_NEXT(a_stall_hold, !en, $stable(valid_reg) && m_valid)
    `SRI_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, valid_reg[0])

endmodule

// File: sv/sri_regs.sv
// APB configuration registers of the Sellmeier block: band limits and terms.
// Depends on sri_pkg.
module sri_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sri_pkg::ADDR_W-1:0]  paddr,
    input  logic [sri_pkg::DATA_W-1:0]  pwdata,
    output logic [sri_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output sri_pkg::cfg_t               cfg
);

    logic [sri_pkg::WAVE_W-1:0] min_reg, max_reg;
    logic [sri_pkg::TERM_MAX-1:0][sri_pkg::TERM_W-1:0] term_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[sri_pkg::ADDR_W-1:3];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= '0;
            max_reg  <= '1;
            term_reg <= '0;
        end else if (wr) begin
            unique case (idx)
                sri_pkg::REG_MIN:   min_reg     <= pwdata[sri_pkg::WAVE_W-1:0];
                sri_pkg::REG_MAX:   max_reg     <= pwdata[sri_pkg::WAVE_W-1:0];
                sri_pkg::REG_TERM1: term_reg[0] <= pwdata;
                sri_pkg::REG_TERM2: term_reg[1] <= pwdata;
                sri_pkg::REG_TERM3: term_reg[2] <= pwdata;
                sri_pkg::REG_TERM4: term_reg[3] <= pwdata;
                sri_pkg::REG_TERM5: term_reg[4] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            sri_pkg::REG_MIN:   prdata = sri_pkg::DATA_W'(min_reg);
            sri_pkg::REG_MAX:   prdata = sri_pkg::DATA_W'(max_reg);
            sri_pkg::REG_TERM1: prdata = term_reg[0];
            sri_pkg::REG_TERM2: prdata = term_reg[1];
            sri_pkg::REG_TERM3: prdata = term_reg[2];
            sri_pkg::REG_TERM4: prdata = term_reg[3];
            sri_pkg::REG_TERM5: prdata = term_reg[4];
            default:            prdata = '0;
        endcase
    end

    assign cfg.min_wave = min_reg;
    assign cfg.max_wave = max_reg;
    assign cfg.term     = term_reg;

endmodule

// File: sv/sri_udiv.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with a tag
// carried alongside. Requires num < den * 2**QW. No package dependency.
module sri_udiv #(
    parameter int NW = 53,
    parameter int DW = 20,
    parameter int QW = 33,
    parameter int TW = 1
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [TW-1:0] tag_in,
    output logic [QW-1:0] quo,
    output logic [TW-1:0] tag_out
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  rem_reg [1:QW-1];
    logic [DW-1:0] den_reg [1:QW-1];
    logic [QW-1:0] q_reg   [1:QW];
    logic [TW-1:0] tag_reg [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [W-1:0]  r_in;
        logic [DW-1:0] d_in;
        logic [QW-1:0] q_in;
        logic [TW-1:0] t_in;
        logic [W-1:0]  sh;
        logic          ge;

        if (k == 0) begin : g_first
            assign r_in = W'(num);
            assign d_in = den;
            assign q_in = '0;
            assign t_in = tag_in;
        end else begin : g_rest
            assign r_in = rem_reg[k];
            assign d_in = den_reg[k];
            assign q_in = q_reg[k];
            assign t_in = tag_reg[k];
        end

        assign sh = W'(d_in) << (QW - 1 - k);
        assign ge = r_in >= sh;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1]   <= QW'({q_in, ge});
                tag_reg[k+1] <= t_in;
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= ge ? r_in - sh : r_in;
                    den_reg[k+1] <= d_in;
                end
            end
        end
    end

    assign quo     = q_reg[QW];
    assign tag_out = tag_reg[QW];

endmodule

// File: sv/sri_isqrt.sv
// Pipelined integer square root, one root bit per stage, with a tag carried
// alongside. Depends on sri_pkg for widths.
module sri_isqrt #(
    parameter int TW = 3
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [sri_pkg::SQ_W-1:0]  rad_in,
    input  logic [TW-1:0]             tag_in,
    output logic [sri_pkg::N_W-1:0]   root,
    output logic [TW-1:0]             tag_out
);

    localparam int SW = sri_pkg::SQ_W;
    localparam int NS = sri_pkg::SQ_STAGES;

    logic [SW-1:0] x_reg   [1:NS-1];
    logic [SW-1:0] r_reg   [1:NS];
    logic [TW-1:0] tag_reg [1:NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [SW-1:0] x_in, r_in, b, t;
        logic [TW-1:0] tg_in;
        logic          ge;

        if (k == 0) begin : g_first
            assign x_in  = rad_in;
            assign r_in  = '0;
            assign tg_in = tag_in;
        end else begin : g_rest
            assign x_in  = x_reg[k];
            assign r_in  = r_reg[k];
            assign tg_in = tag_reg[k];
        end

        assign b  = SW'(1) << (SW - 2 - 2 * k);
        assign t  = r_in + b;
        assign ge = x_in >= t;

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k+1]   <= ge ? (r_in >> 1) + b : r_in >> 1;
                tag_reg[k+1] <= tg_in;
            end
        end

        if (k < NS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[k+1] <= ge ? x_in - t : x_in;
                end
            end
        end
    end

    assign root    = r_reg[NS][sri_pkg::N_W-1:0];
    assign tag_out = tag_reg[NS];

endmodule
